[design/terrain_height_triangle_probe_defines.svh]
// assertion macros used by the checker file
`ifndef TERRAIN_HEIGHT_TRIANGLE_PROBE_DEFINES_SVH
`define TERRAIN_HEIGHT_TRIANGLE_PROBE_DEFINES_SVH

// same-cycle implication
`define THTP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("thtp check failed");

// next-cycle implication
`define THTP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("thtp check failed");

`endif

[design/thtp_pkg.sv]
`timescale 1ns / 1ps

package thtp_pkg;

  // datapath widths
  localparam int CRD_W     = 32;
  localparam int DIF_W     = CRD_W + 1;
  localparam int NRM_W     = 2 * DIF_W + 1;
  localparam int PRD_W     = 100;
  localparam int ACC_W     = PRD_W + 1;
  localparam int QUO_W     = 100;
  localparam int Z_W       = QUO_W + 2;
  localparam int NOUT_W    = 64;
  localparam int CFG_IDX_W = 8;

  localparam int FLOOR_UNITS = -1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X = 8'd0,
    REG_QUERY_Y = 8'd1,
    REG_FLOOR   = 8'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [CRD_W-1:0] az;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by_coord;
    logic signed [CRD_W-1:0] bz;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] cz;
    logic                    last_triangle;
  } tri_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CRD_W-1:0]  height;
    logic signed [NOUT_W-1:0] normal_x;
    logic signed [NOUT_W-1:0] normal_y;
    logic signed [NOUT_W-1:0] normal_z;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // product schedule in pairs: second subtracted, but added in SP_NUM
  typedef enum logic [3:0] {
    SP_AB_0, SP_AB_1,
    SP_AC_0, SP_AC_1,
    SP_BC_0, SP_BC_1,
    SP_NX_0, SP_NX_1,
    SP_NY_0, SP_NY_1,
    SP_NZ_0, SP_NZ_1,
    SP_NUM_0, SP_NUM_1
  } step_t;

  // clamp a normal component to 64 bits
  function automatic logic signed [NOUT_W-1:0] sat64(input logic signed [NRM_W-1:0] v);
    logic signed [NOUT_W-1:0] r;
    if (v[NRM_W-1:NOUT_W-1] == {(NRM_W-NOUT_W+1){v[NOUT_W-1]}}) begin
      r = v[NOUT_W-1:0];
    end else if (v[NRM_W-1]) begin
      r = {1'b1, {(NOUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(NOUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp a height sum to 32 bits
  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [Z_W-1:0] v);
    logic signed [CRD_W-1:0] r;
    if (v[Z_W-1:CRD_W-1] == {(Z_W-CRD_W+1){v[CRD_W-1]}}) begin
      r = v[CRD_W-1:0];
    end else if (v[Z_W-1]) begin
      r = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(CRD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[design/thtp_if.sv]
`timescale 1ns / 1ps

// triangle channel
interface thtp_tri_if;
  logic          valid;
  logic          ready;
  thtp_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface thtp_res_if;
  logic          valid;
  logic          ready;
  thtp_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// register write channel
interface thtp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [thtp_pkg::CFG_IDX_W-1:0]      index;
  logic [thtp_pkg::CRD_W-1:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/thtp_mul.sv]
`timescale 1ns / 1ps

// signed multiplier, one 32x32 partial product per cycle, top chunk first
module thtp_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [thtp_pkg::NRM_W-1:0]   a,
  input  logic signed [thtp_pkg::DIF_W-1:0]   b,
  output logic                                done,
  output logic signed [thtp_pkg::PRD_W-1:0]   p
);

  localparam int CH     = 32;
  localparam int CHUNKS = 3;
  localparam int MAG_W  = CH * CHUNKS;

  logic [MAG_W-1:0]             amag;
  logic [CH-1:0]                bmag;
  logic                         neg;
  logic [1:0]                   cnt;
  logic                         run;
  logic [thtp_pkg::PRD_W-1:0]   pmag;
  logic [thtp_pkg::PRD_W-1:0]   pmag_next;
  logic [CH-1:0]                chunk;
  logic [2*CH-1:0]              part;
  logic signed [thtp_pkg::NRM_W-1:0] a_abs;
  logic signed [thtp_pkg::DIF_W-1:0] b_abs;

  // operand magnitudes
  assign a_abs = a[thtp_pkg::NRM_W-1] ? -a : a;
  assign b_abs = b[thtp_pkg::DIF_W-1] ? -b : b;

  // chunk select and partial product
  always_comb begin
    case (cnt)
      2'd2:    chunk = amag[3*CH-1:2*CH];
      2'd1:    chunk = amag[2*CH-1:CH];
      default: chunk = amag[CH-1:0];
    endcase
    part      = chunk * bmag;
    pmag_next = {pmag[thtp_pkg::PRD_W-CH-1:0], {CH{1'b0}}}
                + {{(thtp_pkg::PRD_W-2*CH){1'b0}}, part};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 2'(CHUNKS - 1);
      end else if (run) begin
        if (cnt == 2'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 2'd1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      amag <= {{(MAG_W-thtp_pkg::NRM_W){1'b0}}, a_abs};
      bmag <= b_abs[CH-1:0];
      neg  <= a[thtp_pkg::NRM_W-1] ^ b[thtp_pkg::DIF_W-1];
      pmag <= '0;
    end else if (run) begin
      pmag <= pmag_next;
    end
  end

  assign p = neg ? $signed(~pmag + 1'b1) : $signed(pmag);

endmodule

[design/thtp_div.sv]
`timescale 1ns / 1ps

// restoring signed divider, one quotient bit per cycle, truncates toward zero
module thtp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [thtp_pkg::ACC_W-1:0]   num,
  input  logic signed [thtp_pkg::NRM_W-1:0]   den,
  output logic                                done,
  output logic signed [thtp_pkg::QUO_W:0]     q
);

  localparam int QW    = thtp_pkg::QUO_W;
  localparam int DW    = thtp_pkg::NRM_W;
  localparam int CNT_W = $clog2(QW);

  logic [QW-1:0]    qn;
  logic [DW-1:0]    dmag;
  logic [DW-1:0]    rem;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_dif;
  logic             ge;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic signed [thtp_pkg::ACC_W-1:0] num_abs;
  logic signed [DW-1:0]              den_abs;

  assign num_abs = num[thtp_pkg::ACC_W-1] ? -num : num;
  assign den_abs = den[DW-1] ? -den : den;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem, qn[QW-1]};
    rem_dif = rem_sh - {1'b0, dmag};
    ge      = rem_sh >= {1'b0, dmag};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(QW - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      qn   <= num_abs[QW-1:0];
      dmag <= den_abs;
      rem  <= '0;
      neg  <= num[thtp_pkg::ACC_W-1] ^ den[DW-1];
    end else if (run) begin
      rem <= ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
      qn  <= {qn[QW-2:0], ge};
    end
  end

  assign q = neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});

endmodule

[design/terrain_height_triangle_probe.sv]
`timescale 1ns / 1ps

// Terrain height probe over a stream of triangles.
// Channels: tri_in takes one triangle per beat (three Q24.8 vertices and a
// last_triangle mark); res_out gives one beat per probe (hit, height, normal);
// cfg writes query_x (0), query_y (1) and floor_height (2), always ready.
// Each triangle is worked through by one 32x32 multiplier used for up to
// fourteen products and a one-bit-per-cycle divider of 100 steps. A triangle
// that misses the query point stops after the edge tests; one whose plane is
// vertical stops after the normal; a covering triangle goes on to the
// numerator and the divider. A last triangle adds the emit state.
// tri_in is ready only while no triangle is in work.
// On the last triangle the result is loaded into an output register and the
// probe state goes back to the floor; a further triangle is taken while the
// result waits, and only the next last triangle waits for it to be taken.
// Reset (rst, synchronous) sets the query point to zero, the floor to minus
// one million units, and clears the probe state and the output valid flag.
module terrain_height_triangle_probe #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic             clk,
  input  logic             rst,
  thtp_tri_if.sink         tri_in,
  thtp_res_if.source       res_out,
  thtp_cfg_if.sink         cfg
);

  localparam int CW = thtp_pkg::CRD_W;
  localparam int DW = thtp_pkg::DIF_W;
  localparam int NW = thtp_pkg::NRM_W;
  localparam int AW = thtp_pkg::ACC_W;
  localparam int PW = thtp_pkg::PRD_W;
  localparam int QW = thtp_pkg::QUO_W;
  localparam int ZW = thtp_pkg::Z_W;
  localparam int SH = CW - COORD_WIDTH;
  localparam longint FLOOR_FULL = longint'(thtp_pkg::FLOOR_UNITS) * (longint'(1) << FRAC_BITS);
  localparam logic signed [CW-1:0] FLOOR_RESET =
    (FLOOR_FULL < -64'sd2147483648) ? {1'b1, {(CW-1){1'b0}}} : CW'(FLOOR_FULL);

  // low coordinate bits, sign-extended
  function automatic logic signed [CW-1:0] crd(input logic [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = $signed(v << SH);
    return t >>> SH;
  endfunction

  function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] u,
                                               input logic signed [CW-1:0] v);
    return {u[CW-1], u} - {v[CW-1], v};
  endfunction

  function automatic logic signed [NW-1:0] ext(input logic signed [DW-1:0] v);
    return {{(NW-DW){v[DW-1]}}, v};
  endfunction

  thtp_pkg::state_t state, state_next;
  thtp_pkg::step_t  step, step_next;

  thtp_pkg::tri_t       tri_r;
  logic signed [CW-1:0] query_x, query_y, floor_height, best_height;
  logic signed [thtp_pkg::NOUT_W-1:0] best_nx, best_ny, best_nz;
  logic                 any_hit;
  logic signed [AW-1:0] acc, acc_sum;
  logic signed [NW-1:0] nx, ny, nz;
  logic                 flag_ab, flag_ac, pos_sum, inside_now;
  logic                 res_valid;
  thtp_pkg::res_t       res_data;
  logic                 tri_fire, emit_fire;

  logic signed [CW-1:0] qx, qy;
  logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y;
  logic signed [DW-1:0] dxa, dya, dxb, dyb, pax, pay;
  logic signed [NW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [PW-1:0] mul_p;
  logic signed [QW:0]   div_q;
  logic signed [ZW-1:0] z_sum;
  logic signed [CW-1:0] z;

  assign qx = crd(query_x);
  assign qy = crd(query_y);

  // edge vectors
  assign e1x = dif(tri_r.bx, tri_r.ax);
  assign e1y = dif(tri_r.by_coord, tri_r.ay);
  assign e1z = dif(tri_r.bz, tri_r.az);
  assign e2x = dif(tri_r.cx, tri_r.ax);
  assign e2y = dif(tri_r.cy, tri_r.ay);
  assign e2z = dif(tri_r.cz, tri_r.az);
  assign e3x = dif(tri_r.cx, tri_r.bx);
  assign e3y = dif(tri_r.cy, tri_r.by_coord);
  assign dxa = dif(qx, tri_r.ax);
  assign dya = dif(qy, tri_r.ay);
  assign dxb = dif(qx, tri_r.bx);
  assign dyb = dif(qy, tri_r.by_coord);
  assign pax = dif(tri_r.ax, qx);
  assign pay = dif(tri_r.ay, qy);

  // operand select per schedule step
  always_comb begin
    case (step)
      thtp_pkg::SP_AB_0:  begin mul_a = ext(e1x); mul_b = dya; end
      thtp_pkg::SP_AB_1:  begin mul_a = ext(e1y); mul_b = dxa; end
      thtp_pkg::SP_AC_0:  begin mul_a = ext(e2x); mul_b = dya; end
      thtp_pkg::SP_AC_1:  begin mul_a = ext(e2y); mul_b = dxa; end
      thtp_pkg::SP_BC_0:  begin mul_a = ext(e3x); mul_b = dyb; end
      thtp_pkg::SP_BC_1:  begin mul_a = ext(e3y); mul_b = dxb; end
      thtp_pkg::SP_NX_0:  begin mul_a = ext(e1y); mul_b = e2z; end
      thtp_pkg::SP_NX_1:  begin mul_a = ext(e1z); mul_b = e2y; end
      thtp_pkg::SP_NY_0:  begin mul_a = ext(e1z); mul_b = e2x; end
      thtp_pkg::SP_NY_1:  begin mul_a = ext(e1x); mul_b = e2z; end
      thtp_pkg::SP_NZ_0:  begin mul_a = ext(e1x); mul_b = e2y; end
      thtp_pkg::SP_NZ_1:  begin mul_a = ext(e1y); mul_b = e2x; end
      thtp_pkg::SP_NUM_0: begin mul_a = nx;       mul_b = pax; end
      thtp_pkg::SP_NUM_1: begin mul_a = ny;       mul_b = pay; end
      default:            begin mul_a = '0;       mul_b = '0;  end
    endcase
  end

  thtp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  thtp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (nz),
    .done  (div_done),
    .q     (div_q)
  );

  // accumulate pairs of products
  always_comb begin
    if (!step[0]) begin
      acc_sum = {{(AW-PW){mul_p[PW-1]}}, mul_p};
    end else if (step == thtp_pkg::SP_NUM_1) begin
      acc_sum = acc + {{(AW-PW){mul_p[PW-1]}}, mul_p};
    end else begin
      acc_sum = acc - {{(AW-PW){mul_p[PW-1]}}, mul_p};
    end
    pos_sum    = !acc_sum[AW-1] && (acc_sum != '0);
    inside_now = (flag_ac != flag_ab) && (pos_sum == flag_ab);
  end

  // plane height at the query point
  assign z_sum = {{(ZW-CW){tri_r.az[CW-1]}}, tri_r.az} + {{(ZW-QW-1){div_q[QW]}}, div_q};
  assign z     = thtp_pkg::sat32(z_sum);

  assign tri_fire  = tri_in.valid && tri_in.ready;
  assign emit_fire = (state == thtp_pkg::ST_EMIT) && (!res_valid || res_out.ready);

  // sequencer next state
  always_comb begin
    state_next = state;
    step_next  = step;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    case (state)
      thtp_pkg::ST_IDLE: begin
        if (tri_in.valid) begin
          state_next = thtp_pkg::ST_MUL_GO;
          step_next  = thtp_pkg::SP_AB_0;
        end
      end
      thtp_pkg::ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = thtp_pkg::ST_MUL_WAIT;
      end
      thtp_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          case (step)
            thtp_pkg::SP_BC_1: begin
              if (inside_now) begin
                step_next  = thtp_pkg::SP_NX_0;
                state_next = thtp_pkg::ST_MUL_GO;
              end else begin
                state_next = thtp_pkg::ST_FINISH;
              end
            end
            thtp_pkg::SP_NZ_1: begin
              if (acc_sum != '0) begin
                step_next  = thtp_pkg::SP_NUM_0;
                state_next = thtp_pkg::ST_MUL_GO;
              end else begin
                state_next = thtp_pkg::ST_FINISH;
              end
            end
            thtp_pkg::SP_NUM_1: begin
              state_next = thtp_pkg::ST_DIV_GO;
            end
            default: begin
              step_next  = thtp_pkg::step_t'(step + 4'd1);
              state_next = thtp_pkg::ST_MUL_GO;
            end
          endcase
        end
      end
      thtp_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = thtp_pkg::ST_DIV_WAIT;
      end
      thtp_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = thtp_pkg::ST_UPDATE;
        end
      end
      thtp_pkg::ST_UPDATE: begin
        state_next = thtp_pkg::ST_FINISH;
      end
      thtp_pkg::ST_FINISH: begin
        state_next = tri_r.last_triangle ? thtp_pkg::ST_EMIT : thtp_pkg::ST_IDLE;
      end
      thtp_pkg::ST_EMIT: begin
        if (!res_valid || res_out.ready) begin
          state_next = thtp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = thtp_pkg::ST_IDLE;
      end
    endcase
  end

  // control, registers and probe state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= thtp_pkg::ST_IDLE;
      step         <= thtp_pkg::SP_AB_0;
      query_x      <= '0;
      query_y      <= '0;
      floor_height <= FLOOR_RESET;
      best_height  <= FLOOR_RESET;
      best_nx      <= '0;
      best_ny      <= '0;
      best_nz      <= '0;
      any_hit      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (res_valid && res_out.ready) begin
        res_valid <= 1'b0;
      end
      // register writes
      if (cfg.valid) begin
        if (cfg.index == thtp_pkg::REG_QUERY_X) begin
          query_x <= cfg.data;
        end else if (cfg.index == thtp_pkg::REG_QUERY_Y) begin
          query_y <= cfg.data;
        end else if (cfg.index == thtp_pkg::REG_FLOOR) begin
          floor_height <= cfg.data;
          if (!any_hit) begin
            best_height <= cfg.data;
          end
        end
      end
      // keep the highest covering plane
      if (state == thtp_pkg::ST_UPDATE) begin
        any_hit <= 1'b1;
        if (z > best_height) begin
          best_height <= z;
          best_nx     <= thtp_pkg::sat64(nx);
          best_ny     <= thtp_pkg::sat64(ny);
          best_nz     <= thtp_pkg::sat64(nz);
        end
      end
      // emit and restore the floor
      if (emit_fire) begin
        res_valid   <= 1'b1;
        best_height <= floor_height;
        best_nx     <= '0;
        best_ny     <= '0;
        best_nz     <= '0;
        any_hit     <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tri_fire) begin
      tri_r.ax            <= crd(tri_in.data.ax);
      tri_r.ay            <= crd(tri_in.data.ay);
      tri_r.az            <= crd(tri_in.data.az);
      tri_r.bx            <= crd(tri_in.data.bx);
      tri_r.by_coord      <= crd(tri_in.data.by_coord);
      tri_r.bz            <= crd(tri_in.data.bz);
      tri_r.cx            <= crd(tri_in.data.cx);
      tri_r.cy            <= crd(tri_in.data.cy);
      tri_r.cz            <= crd(tri_in.data.cz);
      tri_r.last_triangle <= tri_in.data.last_triangle;
    end
    if ((state == thtp_pkg::ST_MUL_WAIT) && mul_done) begin
      acc <= acc_sum;
      case (step)
        thtp_pkg::SP_AB_1: flag_ab <= pos_sum;
        thtp_pkg::SP_AC_1: flag_ac <= pos_sum;
        thtp_pkg::SP_NX_1: nx      <= acc_sum[NW-1:0];
        thtp_pkg::SP_NY_1: ny      <= acc_sum[NW-1:0];
        thtp_pkg::SP_NZ_1: nz      <= acc_sum[NW-1:0];
        default: ;
      endcase
    end
    if (emit_fire) begin
      res_data.hit      <= any_hit;
      res_data.height   <= best_height;
      res_data.normal_x <= best_nx;
      res_data.normal_y <= best_ny;
      res_data.normal_z <= best_nz;
    end
  end

  assign tri_in.ready  = (state == thtp_pkg::ST_IDLE);
  assign res_out.valid = res_valid;
  assign res_out.data  = res_data;
  assign cfg.ready     = 1'b1;

endmodule

[design/thtp_chk.sv]
`include "terrain_height_triangle_probe_defines.svh"
`timescale 1ns / 1ps

// port-level checks
module thtp_chk (
  input logic           clk,
  input logic           rst,
  input logic           tri_valid,
  input logic           tri_ready,
  input logic           res_valid,
  input logic           res_ready,
  input thtp_pkg::res_t res_data
);

  // a triangle beat leaves the block busy in the cycle after it
  `THTP_ASSERT_NXT(a_busy_after_beat, clk, rst, tri_valid && tri_ready, !tri_ready)

  // a stalled result holds
  `THTP_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data))

  // no hit means no normal
  `THTP_ASSERT_NOW(a_miss_zero_normal, clk, rst, res_valid && !res_data.hit, (res_data.normal_x == '0) && (res_data.normal_y == '0) && (res_data.normal_z == '0))

  // a new result only comes out of a triangle in work
  `THTP_ASSERT_NOW(a_res_from_work, clk, rst, $rose(res_valid), $past(!tri_ready))

endmodule

bind terrain_height_triangle_probe thtp_chk u_thtp_chk (
  .clk       (clk),
  .rst       (rst),
  .tri_valid (tri_in.valid),
  .tri_ready (tri_in.ready),
  .res_valid (res_out.valid),
  .res_ready (res_out.ready),
  .res_data  (res_out.data)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [191:0] wide_t;

  localparam logic [thtp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
  localparam logic signed [63:0] MAX64 = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] FLOOR_RESET = thtp_pkg::FLOOR_UNITS * 256;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD = 3000;
  localparam int N_ROWS = 13;

  logic clk;
  logic rst;

  thtp_tri_if tri_ch ();
  thtp_res_if res_ch ();
  thtp_cfg_if cfg_ch ();

  terrain_height_triangle_probe uut (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_ch.sink),
    .res_out(res_ch.source),
    .cfg(cfg_ch.sink)
  );

  // probe state mirror
  logic signed [31:0] qx_m, qy_m, floor_m, best_h;
  logic signed [63:0] best_n [3];
  bit probe_hit;
  thtp_pkg::res_t pending_probes [$];
  int fail_count = 0;
  bit sink_gaps_on = 1;
  bit hold_req = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic wide_t side_test(input logic signed [31:0] px, py, qx, qy, x, y);
    return (wide_t'(qx) - wide_t'(px)) * (wide_t'(y) - wide_t'(py)) -
           (wide_t'(qy) - wide_t'(py)) * (wide_t'(x) - wide_t'(px));
  endfunction

  function automatic logic signed [63:0] clamp64(input wide_t v);
    if (v > wide_t'(MAX64)) return MAX64;
    if (v < wide_t'(MIN64)) return MIN64;
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > wide_t'(MAX32)) return MAX32;
    if (v < wide_t'(MIN32)) return MIN32;
    return v[31:0];
  endfunction

  // fold one triangle into the probe; returns 1 when a probe result is due
  function automatic bit probe_triangle(input thtp_pkg::tri_t t, output thtp_pkg::res_t r);
    bit s;
    wide_t e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, num;
    logic signed [31:0] z;
    s = side_test(t.ax, t.ay, t.bx, t.by_coord, qx_m, qy_m) > 0;
    if (((side_test(t.ax, t.ay, t.cx, t.cy, qx_m, qy_m) > 0) != s) &&
        ((side_test(t.bx, t.by_coord, t.cx, t.cy, qx_m, qy_m) > 0) == s)) begin
      e1x = wide_t'(t.bx) - wide_t'(t.ax);
      e1y = wide_t'(t.by_coord) - wide_t'(t.ay);
      e1z = wide_t'(t.bz) - wide_t'(t.az);
      e2x = wide_t'(t.cx) - wide_t'(t.ax);
      e2y = wide_t'(t.cy) - wide_t'(t.ay);
      e2z = wide_t'(t.cz) - wide_t'(t.az);
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      if (nz != 0) begin
        num = nx * (wide_t'(t.ax) - wide_t'(qx_m)) + ny * (wide_t'(t.ay) - wide_t'(qy_m));
        z = clamp32(wide_t'(t.az) + num / nz);
        probe_hit = 1;
        // ties keep the earlier triangle
        if (z > best_h) begin
          best_h = z;
          best_n[0] = clamp64(nx);
          best_n[1] = clamp64(ny);
          best_n[2] = clamp64(nz);
        end
      end
    end
    r = '0;
    if (!t.last_triangle) return 0;
    r.hit = probe_hit;
    r.height = best_h;
    r.normal_x = best_n[0];
    r.normal_y = best_n[1];
    r.normal_z = best_n[2];
    best_h = floor_m;
    best_n = '{0, 0, 0};
    probe_hit = 0;
    return 1;
  endfunction

  task automatic write_reg(input logic [thtp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      thtp_pkg::REG_QUERY_X: qx_m = val;
      thtp_pkg::REG_QUERY_Y: qy_m = val;
      thtp_pkg::REG_FLOOR: begin
        floor_m = val;
        if (!probe_hit) best_h = val;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // offer one triangle, wait for its beat, record what it should cause
  task automatic send_triangle(input thtp_pkg::tri_t t, input bit typed,
                               input thtp_pkg::res_t typed_res, input bit gaps);
    thtp_pkg::res_t r;
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    repeat (gap) @(negedge clk);
    @(negedge clk);
    tri_ch.valid = 1'b1;
    tri_ch.data = t;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    if (probe_triangle(t, r)) begin
      pending_probes.insert(pending_probes.size(), typed ? typed_res : r);
    end
    @(negedge clk);
    tri_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_probes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic thtp_pkg::tri_t random_triangle(input bit last);
    thtp_pkg::tri_t t;
    logic signed [31:0] sx, sy;
    int kind;
    kind = $urandom_range(0, 9);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, 1'b0};
    if (kind < 7) begin
      // triangle drawn around the query point
      t.ax = qx_m - $signed($urandom_range(1, 65535));
      t.ay = qy_m - $signed($urandom_range(1, 65535));
      t.bx = qx_m + $signed($urandom_range(1, 65535));
      t.by_coord = qy_m - $signed($urandom_range(1, 65535));
      t.cx = qx_m + $signed($urandom_range(0, 512)) - 256;
      t.cy = qy_m + $signed($urandom_range(1, 65535));
      if (kind < 5) begin
        t.az = $signed($urandom_range(0, 2097152)) - 1048576;
        t.bz = $signed($urandom_range(0, 2097152)) - 1048576;
        t.cz = $signed($urandom_range(0, 2097152)) - 1048576;
      end
      if (kind == 6) begin
        {t.bx, t.by_coord, t.bz, t.cx, t.cy, t.cz} = {t.cx, t.cy, t.cz, t.bx, t.by_coord, t.bz};
      end
    end else if (kind == 7) begin
      // vertical plane: vertices collinear in x and y
      sx = $signed($urandom_range(0, 4096)) - 2048;
      sy = $signed($urandom_range(0, 4096)) - 2048;
      t.ax = qx_m - sx;
      t.ay = qy_m - sy;
      t.bx = qx_m + sx;
      t.by_coord = qy_m + sy;
      t.cx = qx_m + 2 * sx;
      t.cy = qy_m + 2 * sy;
    end
    t.last_triangle = last;
    return t;
  endfunction

  // result side: random stalls, one long hold on request
  initial begin
    thtp_pkg::res_t got, want;
    int gap;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end
      gap = sink_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      got = res_ch.data;
      if (pending_probes.size() == 0) begin
        report("unexpected beat", 64'(got.height), 64'd0);
      end else begin
        want = pending_probes.pop_front();
        if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.height !== want.height) report("height", 64'(got.height), 64'(want.height));
        if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
        if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
        if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
      end
      @(negedge clk);
    end
  end

  typedef struct {
    thtp_pkg::tri_t shape;
    bit typed;
    thtp_pkg::res_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows [N_ROWS];
    thtp_pkg::tri_t t;
    thtp_pkg::res_t none;
    logic signed [31:0] ph_qx [6];
    logic signed [31:0] ph_qy [6];
    logic signed [31:0] ph_fl [6];
    int n_items;
    none = '0;
    rst = 1'b1;
    tri_ch.valid = 1'b0;
    tri_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    qx_m = 0;
    qy_m = 0;
    floor_m = FLOOR_RESET;
    best_h = FLOOR_RESET;
    best_n = '{0, 0, 0};
    probe_hit = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed triangles at reset settings
    rows = '{
      // all-zero triangle: nothing covered, floor comes back
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1,
        '{1'b0, FLOOR_RESET, 64'sd0, 64'sd0, 64'sd0}},
      // flat triangle over the origin
      '{'{-256, -256, 512, 256, -256, 512, 0, 256, 512, 1'b1}, 1'b1,
        '{1'b1, 32'sd512, 64'sd0, 64'sd0, 64'sd262144}},
      // same triangle reversed winding, then a tie with another normal
      '{'{-256, -256, 512, 0, 256, 512, 256, -256, 512, 1'b0}, 1'b0, none},
      '{'{-512, -512, 768, 512, -512, 256, 0, 512, 512, 1'b1}, 1'b0, none},
      // covered but below the floor
      '{'{-256, -256, MIN32, 256, -256, MIN32, 0, 256, MIN32, 1'b1}, 1'b1,
        '{1'b1, FLOOR_RESET, 64'sd0, 64'sd0, 64'sd0}},
      // vertical plane
      '{'{-256, -256, 0, 256, 256, 1000, 512, 512, -9, 1'b1}, 1'b1,
        '{1'b0, FLOOR_RESET, 64'sd0, 64'sd0, 64'sd0}},
      // height reaches the top of the range, then normals saturate at the coordinate extremes
      '{'{-1, -1, MAX32, 1, -1, MAX32, 0, 1, MAX32 - 1, 1'b0}, 1'b0, none},
      '{'{MIN32, MIN32, MAX32, MAX32, MIN32, MIN32, 0, MAX32, MAX32, 1'b1}, 1'b0, none},
      '{'{MIN32, MIN32, MIN32, MAX32, MIN32, MAX32, MIN32, MAX32, MIN32, 1'b1},
        1'b0, none},
      '{'{MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, 1'b1},
        1'b0, none},
      // several in one probe, highest wins
      '{'{-300, -300, 100, 300, -300, 100, 0, 300, 100, 1'b0}, 1'b0, none},
      '{'{-300, -300, 900, 300, -300, 900, 0, 300, 300, 1'b0}, 1'b0, none},
      '{'{-300, -300, 50, 300, -300, 50, 0, 300, 50, 1'b1}, 1'b0, none}
    };
    foreach (rows[i]) send_triangle(rows[i].shape, rows[i].typed, rows[i].res, 1);
    wait_idle();

    // settings per phase, extremes included
    ph_qx = '{MAX32, 32'sd1000, -32'sd77777, 32'sd0, 32'sd0, 32'sd0};
    ph_qy = '{MIN32, -32'sd5000, 32'sd123456, 32'sd0, 32'sd0, 32'sd0};
    ph_fl = '{MIN32, MAX32, 32'sd0, FLOOR_RESET, 32'sd0, 32'sd0};
    for (int p = 0; p < 6; p++) begin
      if (p >= 3) begin
        ph_qx[p] = $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
        ph_qy[p] = $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
      end
      if (p == 5) ph_fl[p] = $urandom;
      write_reg(thtp_pkg::REG_QUERY_X, ph_qx[p]);
      write_reg(thtp_pkg::REG_QUERY_Y, ph_qy[p]);
      write_reg(thtp_pkg::REG_FLOOR, ph_fl[p]);
      if (p == 2) write_reg(REG_UNUSED, $urandom);
      sink_gaps_on = (p != 4);
      if (p == 1) hold_req = 1;
      n_items = 180;
      for (int i = 0; i < n_items; i++) begin
        // let the block drain completely once mid-phase
        if (p == 3 && i == 90) while (pending_probes.size() != 0) @(posedge clk);
        t = random_triangle((i == n_items - 1) || ($urandom_range(0, 4) == 0));
        send_triangle(t, 0, none, p != 4);
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("terrain_height_triangle_probe regression: pass");
    end else begin
      $display("terrain_height_triangle_probe regression: fail");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("terrain_height_triangle_probe regression: fail");
    $finish;
  end

endmodule
